FILE: design/assert_macros.svh
// Assertion helpers shared by the window stack engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WSEE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("window stack engine: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WSEE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("window stack engine: next-cycle check failed");

`endif

FILE: design/wsee_pkg.sv
package wsee_pkg;

	// Default number of window slots.
	localparam int unsigned MAX_WINDOWS_DEF = 8;

	// Geometry constants on the 16-bit signed working datapath.
	localparam logic signed [15:0] BTN_WIDTH   = 16'sd120;
	localparam logic signed [15:0] BTN_PITCH   = 16'sd124;
	localparam logic signed [15:0] BTN_START   = 16'sd4;
	localparam logic signed [15:0] DRAG_KEEP_X = 16'sd40;
	localparam logic signed [15:0] DRAG_KEEP_Y = 16'sd20;
	localparam logic signed [15:0] CLOSE_INSET = 16'sd4;
	localparam logic signed [15:0] CLOSE_DROP  = 16'sd3;

	// Reset values of the configuration registers.
	localparam logic [11:0] SCREEN_W_RST  = 12'd1024;
	localparam logic [11:0] SCREEN_H_RST  = 12'd768;
	localparam logic [5:0]  TITLE_H_RST   = 6'd24;
	localparam logic [5:0]  CLOSE_SZ_RST  = 6'd16;
	localparam logic [5:0]  TASKBAR_H_RST = 6'd30;

	typedef enum logic [2:0] {
		CMD_CREATE   = 3'd0,
		CMD_DESTROY  = 3'd1,
		CMD_BTN_DOWN = 3'd2,
		CMD_BTN_UP   = 3'd3,
		CMD_MOVE     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_FULL = 2'd1,
		STAT_NONE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CFG_SCREEN_W  = 3'd0,
		CFG_SCREEN_H  = 3'd1,
		CFG_TITLE_H   = 3'd2,
		CFG_CLOSE_SZ  = 3'd3,
		CFG_TASKBAR_H = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STK_NONE,
		STK_PUSH,
		STK_RAISE,
		STK_REMOVE
	} stk_op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_FIND,
		S_TASKBAR,
		S_WIN_RD,
		S_WIN_CMP,
		S_FETCH,
		S_LOAD,
		S_MOVE_WR,
		S_STACK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic signed [12:0] left;
		logic signed [12:0] top;
		logic [11:0]        width;
		logic [11:0]        height;
	} rect_t;

	function automatic logic signed [15:0] sx13(input logic [12:0] v);
		return {{3{v[12]}}, v};
	endfunction

	function automatic logic signed [15:0] sx14(input logic [13:0] v);
		return {{2{v[13]}}, v};
	endfunction

	function automatic logic signed [15:0] zx12(input logic [11:0] v);
		return {4'b0000, v};
	endfunction

	function automatic logic signed [15:0] zx6(input logic [5:0] v);
		return {10'b0000000000, v};
	endfunction

endpackage

FILE: design/wsee_if.sv
// Event request channel.
interface wsee_evt_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [12:0] pos_x;
	logic signed [12:0] pos_y;
	logic [11:0]        rect_width;
	logic [11:0]        rect_height;
	logic [2:0]         target_slot;

	modport source (output valid, cmd, pos_x, pos_y, rect_width, rect_height, target_slot,
		input ready);
	modport sink (input valid, cmd, pos_x, pos_y, rect_width, rect_height, target_slot,
		output ready);
endinterface

// Result request channel.
interface wsee_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [2:0]         slot_out;
	logic [2:0]         top_slot;
	logic [3:0]         open_count;
	logic               drag_active;
	logic               was_closed;
	logic signed [12:0] new_left;
	logic signed [12:0] new_top;

	modport source (output valid, status, slot_out, top_slot, open_count, drag_active,
		was_closed, new_left, new_top, input ready);
	modport sink (input valid, status, slot_out, top_slot, open_count, drag_active,
		was_closed, new_left, new_top, output ready);
endinterface

FILE: design/wsee_rect_ram.sv
// Window rectangle store: one write port, one read port, registered read data.
// The user must read an entry only after it has been written by a create; the block itself does not enforce this.
module wsee_rect_ram #(
	parameter int unsigned DEPTH = wsee_pkg::MAX_WINDOWS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  wsee_pkg::rect_t wdata,
	input  logic [AW-1:0]   raddr,
	output wsee_pkg::rect_t rdata
);

	wsee_pkg::rect_t mem_q [DEPTH];
	wsee_pkg::rect_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/wsee_stack.sv
`include "assert_macros.svh"

// Stacking order (bottom at entry 0), open count and open flags.
module wsee_stack #(
	parameter int unsigned MAX_WINDOWS = wsee_pkg::MAX_WINDOWS_DEF,
	parameter int unsigned SW          = $clog2(MAX_WINDOWS),
	parameter int unsigned CW          = $clog2(MAX_WINDOWS + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  wsee_pkg::stk_op_t      op,
	input  logic [SW-1:0]          op_slot,
	input  logic [SW-1:0]          op_pos,
	input  logic [SW-1:0]          rd_idx,
	output logic [SW-1:0]          rd_slot,
	output logic [CW-1:0]          count,
	output logic [MAX_WINDOWS-1:0] visible,
	output logic [SW-1:0]          free_slot
);

	logic [SW-1:0]          order_q [MAX_WINDOWS];
	logic [CW-1:0]          count_q;
	logic [MAX_WINDOWS-1:0] vis_q;
	logic [SW-1:0]          top_idx;

	assign top_idx = SW'(count_q - CW'(1));

	// Lowest closed slot.
	always_comb begin
		free_slot = '0;
		for (int i = MAX_WINDOWS - 1; i >= 0; i--) begin
			if (!vis_q[i]) begin
				free_slot = SW'(i);
			end
		end
	end

	// Push, raise to top, or remove with the entries above sliding down.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vis_q   <= '0;
			for (int j = 0; j < MAX_WINDOWS; j++) begin
				order_q[j] <= '0;
			end
		end else begin
			case (op)
				wsee_pkg::STK_PUSH: begin
					order_q[count_q[SW-1:0]] <= op_slot;
					vis_q[op_slot]           <= 1'b1;
					count_q                  <= count_q + CW'(1);
				end
				wsee_pkg::STK_RAISE: begin
					for (int j = 0; j < MAX_WINDOWS - 1; j++) begin
						if (CW'(j) >= CW'(op_pos) && CW'(j + 1) < count_q) begin
							order_q[j] <= order_q[j+1];
						end
					end
					order_q[top_idx] <= op_slot;
				end
				wsee_pkg::STK_REMOVE: begin
					for (int j = 0; j < MAX_WINDOWS - 1; j++) begin
						if (CW'(j) >= CW'(op_pos) && CW'(j + 1) < count_q) begin
							order_q[j] <= order_q[j+1];
						end
					end
					vis_q[op_slot] <= 1'b0;
					count_q        <= count_q - CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_slot = order_q[rd_idx];
	assign count   = count_q;
	assign visible = vis_q;

	// The number of open windows equals the stack count.
	`WSEE_ASSERT_IMP(a_count_matches_open, clk, arst_n, 1'b1, $countones(vis_q) == count_q)

endmodule

FILE: design/window_stack_event_engine.sv
// Channel | Dir | Protocol           | Contents
// evt     | in  | valid/ready        | cmd, pos_x, pos_y, rect_width, rect_height, target_slot
// res     | out | valid/ready        | status, slot_out, top_slot, open_count, drag_active,
//         |     |                    | was_closed, new_left, new_top
// cfg     | in  | write enable/index | screen and chrome sizes, no read-back
//
// One event at a time.
// Destroy searches the stack one entry a cycle.
// A button down walks up to N taskbar buttons at one a cycle, then ends the strip and
// walks up to N windows from the top, each through a rectangle memory read and a compare.
// A new event is taken while the previous result still waits in the output register;
// the result of an event waits in its last state until that register is free.
// Reset is asynchronous and needs no clearing pass.
`include "assert_macros.svh"

module window_stack_event_engine #(
	parameter int unsigned MAX_WINDOWS = wsee_pkg::MAX_WINDOWS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_we,
	input logic [2:0]   cfg_idx,
	input logic [11:0]  cfg_wdata,
	wsee_evt_if.sink    evt,
	wsee_res_if.source  res
);

	localparam int unsigned SW = $clog2(MAX_WINDOWS);
	localparam int unsigned CW = $clog2(MAX_WINDOWS + 1);

	wsee_pkg::state_t   state_q, state_d;

	// Configuration.
	logic [11:0]        sw_q, sh_q;
	logic [5:0]         title_h_q, close_sz_q, tb_h_q;

	// Captured event.
	logic [2:0]         cmd_q;
	logic [12:0]        px_q, py_q;
	logic [11:0]        rw_q, rh_q;
	logic [2:0]         tgt_q;

	// Working registers.
	logic [SW-1:0]      slot_q, pos_q;
	logic [CW-1:0]      idx_q;
	logic signed [15:0] bx_q;
	wsee_pkg::status_t  status_q;
	logic               closed_q;
	logic signed [12:0] nl_q, nt_q;
	wsee_pkg::stk_op_t  op_q;

	// Drag state.
	logic               drag_q;
	logic [SW-1:0]      drag_slot_q;
	logic [13:0]        gdx_q, gdy_q;

	// Result register.
	logic               out_valid_q;
	logic [1:0]         res_status_q;
	logic [2:0]         res_slot_q, res_top_q;
	logic [3:0]         res_count_q;
	logic               res_drag_q, res_closed_q;
	logic signed [12:0] res_left_q, res_top_pos_q;

	// Stack and memory connections.
	wsee_pkg::stk_op_t  stk_op;
	logic [SW-1:0]      stk_slot, stk_pos, rd_idx, rd_slot, free_slot;
	logic [CW-1:0]      stk_count;
	logic [MAX_WINDOWS-1:0] visible;
	logic               ram_we;
	logic [SW-1:0]      ram_waddr, ram_raddr;
	wsee_pkg::rect_t    ram_wdata, rd;

	logic               out_free, accept;
	logic [SW-1:0]      idx_m1, top_idx;

	wsee_stack #(.MAX_WINDOWS(MAX_WINDOWS), .SW(SW), .CW(CW)) u_stack (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (stk_op),
		.op_slot  (stk_slot),
		.op_pos   (stk_pos),
		.rd_idx   (rd_idx),
		.rd_slot  (rd_slot),
		.count    (stk_count),
		.visible  (visible),
		.free_slot(free_slot)
	);

	wsee_rect_ram #(.DEPTH(MAX_WINDOWS), .AW(SW)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd)
	);

	assign accept    = evt.valid && evt.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign idx_m1    = SW'(idx_q - CW'(1));
	assign top_idx   = SW'(stk_count - CW'(1));
	assign ram_raddr = (state_q == wsee_pkg::S_WIN_RD) ? rd_slot : slot_q;
	assign evt.ready = (state_q == wsee_pkg::S_IDLE);

	// Geometry on a common 16-bit signed datapath.
	logic signed [15:0] x_p, y_p, l_r, t_r, w_r, h_r, cb, sh, sh_tb;
	logic signed [15:0] right, bottom, cx, cy, mx, my, x_lo, x1, y1, x_hi, x2, y_hi, y2;
	logic               full, dest_ok, move_ok, in_strip, tb_hit, in_win, in_close, in_title;

	always_comb begin
		x_p    = wsee_pkg::sx13(px_q);
		y_p    = wsee_pkg::sx13(py_q);
		l_r    = wsee_pkg::sx13(rd.left);
		t_r    = wsee_pkg::sx13(rd.top);
		w_r    = wsee_pkg::zx12(rd.width);
		h_r    = wsee_pkg::zx12(rd.height);
		cb     = wsee_pkg::zx6(close_sz_q);
		sh     = wsee_pkg::zx12(sh_q);
		sh_tb  = sh - wsee_pkg::zx6(tb_h_q);

		full     = (stk_count == CW'(MAX_WINDOWS));
		dest_ok  = (32'(tgt_q) < MAX_WINDOWS) && visible[SW'(tgt_q)];
		move_ok  = drag_q && visible[drag_slot_q];
		in_strip = (y_p >= sh_tb) && (y_p < sh);
		tb_hit   = (x_p >= bx_q) && (x_p < bx_q + wsee_pkg::BTN_WIDTH);

		// Window body, close box and title bar tests.
		right    = l_r + w_r;
		bottom   = t_r + h_r;
		cx       = right - cb - wsee_pkg::CLOSE_INSET;
		cy       = t_r + wsee_pkg::CLOSE_DROP;
		in_win   = (x_p >= l_r) && (x_p < right) && (y_p >= t_r) && (y_p < bottom);
		in_close = (x_p >= cx) && (x_p < cx + cb) && (y_p >= cy) && (y_p < cy + cb);
		in_title = y_p < t_r + wsee_pkg::zx6(title_h_q);

		// Drag target, clamped in a fixed order where the later clamp wins.
		mx   = x_p - wsee_pkg::sx14(gdx_q);
		my   = y_p - wsee_pkg::sx14(gdy_q);
		x_lo = wsee_pkg::DRAG_KEEP_X - w_r;
		x1   = (mx < x_lo) ? x_lo : mx;
		y1   = (my < 16'sd0) ? 16'sd0 : my;
		x_hi = wsee_pkg::zx12(sw_q) - wsee_pkg::DRAG_KEEP_X;
		x2   = (x1 > x_hi) ? x_hi : x1;
		y_hi = sh_tb - wsee_pkg::DRAG_KEEP_Y;
		y2   = (y1 > y_hi) ? y_hi : y1;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsee_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, stack operations and memory accesses.
	always_comb begin
		state_d   = state_q;
		stk_op    = wsee_pkg::STK_NONE;
		stk_slot  = slot_q;
		stk_pos   = pos_q;
		rd_idx    = idx_q[SW-1:0];
		ram_we    = 1'b0;
		ram_waddr = free_slot;
		ram_wdata = '{left: px_q, top: py_q, width: rw_q, height: rh_q};
		case (state_q)
			wsee_pkg::S_IDLE: begin
				if (evt.valid) begin
					state_d = wsee_pkg::S_DECODE;
				end
			end
			wsee_pkg::S_DECODE: begin
				state_d = wsee_pkg::S_DONE;
				case (cmd_q)
					wsee_pkg::CMD_CREATE: begin
						if (!full) begin
							ram_we   = 1'b1;
							stk_op   = wsee_pkg::STK_PUSH;
							stk_slot = free_slot;
						end
					end
					wsee_pkg::CMD_DESTROY: begin
						if (dest_ok) begin
							state_d = wsee_pkg::S_FIND;
						end
					end
					wsee_pkg::CMD_BTN_DOWN: begin
						state_d = in_strip ? wsee_pkg::S_TASKBAR : wsee_pkg::S_WIN_RD;
					end
					wsee_pkg::CMD_BTN_UP: begin
						if (drag_q) begin
							state_d = wsee_pkg::S_FETCH;
						end
					end
					wsee_pkg::CMD_MOVE: begin
						if (move_ok) begin
							state_d = wsee_pkg::S_FETCH;
						end
					end
					default: begin
					end
				endcase
			end
			wsee_pkg::S_FIND: begin
				if (rd_slot == slot_q) begin
					state_d = wsee_pkg::S_FETCH;
				end
			end
			wsee_pkg::S_TASKBAR: begin
				if (idx_q == stk_count) begin
					state_d = wsee_pkg::S_WIN_RD;
				end else if (tb_hit) begin
					state_d = wsee_pkg::S_FETCH;
				end
			end
			wsee_pkg::S_WIN_RD: begin
				rd_idx  = idx_m1;
				state_d = (idx_q == '0) ? wsee_pkg::S_DONE : wsee_pkg::S_WIN_CMP;
			end
			wsee_pkg::S_WIN_CMP: begin
				state_d = in_win ? wsee_pkg::S_STACK : wsee_pkg::S_WIN_RD;
			end
			wsee_pkg::S_FETCH: begin
				state_d = (cmd_q == wsee_pkg::CMD_MOVE) ? wsee_pkg::S_MOVE_WR : wsee_pkg::S_LOAD;
			end
			wsee_pkg::S_LOAD: begin
				state_d = wsee_pkg::S_STACK;
			end
			wsee_pkg::S_MOVE_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q;
				ram_wdata = '{left: 13'(x2), top: 13'(y2), width: rd.width, height: rd.height};
				state_d   = wsee_pkg::S_DONE;
			end
			wsee_pkg::S_STACK: begin
				stk_op  = op_q;
				state_d = wsee_pkg::S_DONE;
			end
			wsee_pkg::S_DONE: begin
				rd_idx = top_idx;
				if (out_free) begin
					state_d = wsee_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = wsee_pkg::S_IDLE;
			end
		endcase
	end

	// Event capture and working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= evt.cmd;
			px_q  <= evt.pos_x;
			py_q  <= evt.pos_y;
			rw_q  <= evt.rect_width;
			rh_q  <= evt.rect_height;
			tgt_q <= evt.target_slot;
		end
		case (state_q)
			wsee_pkg::S_DECODE: begin
				status_q <= wsee_pkg::STAT_NONE;
				closed_q <= 1'b0;
				op_q     <= wsee_pkg::STK_NONE;
				idx_q    <= '0;
				bx_q     <= wsee_pkg::BTN_START;
				case (cmd_q)
					wsee_pkg::CMD_CREATE: begin
						status_q <= full ? wsee_pkg::STAT_FULL : wsee_pkg::STAT_DONE;
						slot_q   <= free_slot;
						nl_q     <= px_q;
						nt_q     <= py_q;
					end
					wsee_pkg::CMD_DESTROY: begin
						slot_q <= SW'(tgt_q);
						op_q   <= wsee_pkg::STK_REMOVE;
						if (dest_ok) begin
							status_q <= wsee_pkg::STAT_DONE;
						end
					end
					wsee_pkg::CMD_BTN_DOWN: begin
						if (!in_strip) begin
							idx_q <= stk_count;
						end
					end
					wsee_pkg::CMD_BTN_UP: begin
						slot_q <= drag_slot_q;
						if (drag_q) begin
							status_q <= wsee_pkg::STAT_DONE;
						end
					end
					wsee_pkg::CMD_MOVE: begin
						slot_q <= drag_slot_q;
						if (move_ok) begin
							status_q <= wsee_pkg::STAT_DONE;
						end
					end
					default: begin
					end
				endcase
			end
			wsee_pkg::S_FIND: begin
				if (rd_slot == slot_q) begin
					pos_q <= idx_q[SW-1:0];
				end else begin
					idx_q <= idx_q + CW'(1);
				end
			end
			wsee_pkg::S_TASKBAR: begin
				if (idx_q != stk_count) begin
					if (tb_hit) begin
						slot_q   <= rd_slot;
						pos_q    <= idx_q[SW-1:0];
						op_q     <= wsee_pkg::STK_RAISE;
						status_q <= wsee_pkg::STAT_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
						bx_q  <= bx_q + wsee_pkg::BTN_PITCH;
					end
				end
			end
			wsee_pkg::S_WIN_RD: begin
				slot_q <= rd_slot;
				pos_q  <= idx_m1;
			end
			wsee_pkg::S_WIN_CMP: begin
				if (in_win) begin
					status_q <= wsee_pkg::STAT_DONE;
					nl_q     <= rd.left;
					nt_q     <= rd.top;
					// A close after a raise is the same as removing from where it stood.
					if (in_close) begin
						op_q     <= wsee_pkg::STK_REMOVE;
						closed_q <= 1'b1;
					end else begin
						op_q <= wsee_pkg::STK_RAISE;
					end
				end else begin
					idx_q <= idx_q - CW'(1);
				end
			end
			wsee_pkg::S_LOAD: begin
				nl_q <= rd.left;
				nt_q <= rd.top;
			end
			wsee_pkg::S_MOVE_WR: begin
				nl_q <= 13'(x2);
				nt_q <= 13'(y2);
			end
			default: begin
			end
		endcase
	end

	// Configuration, drag state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q        <= wsee_pkg::SCREEN_W_RST;
			sh_q        <= wsee_pkg::SCREEN_H_RST;
			title_h_q   <= wsee_pkg::TITLE_H_RST;
			close_sz_q  <= wsee_pkg::CLOSE_SZ_RST;
			tb_h_q      <= wsee_pkg::TASKBAR_H_RST;
			drag_q      <= 1'b0;
			drag_slot_q <= '0;
			gdx_q       <= '0;
			gdy_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					wsee_pkg::CFG_SCREEN_W:  sw_q       <= cfg_wdata;
					wsee_pkg::CFG_SCREEN_H:  sh_q       <= cfg_wdata;
					wsee_pkg::CFG_TITLE_H:   title_h_q  <= cfg_wdata[5:0];
					wsee_pkg::CFG_CLOSE_SZ:  close_sz_q <= cfg_wdata[5:0];
					wsee_pkg::CFG_TASKBAR_H: tb_h_q     <= cfg_wdata[5:0];
					default: begin
					end
				endcase
			end
			if (state_q == wsee_pkg::S_DECODE && cmd_q == wsee_pkg::CMD_BTN_UP) begin
				drag_q      <= 1'b0;
				drag_slot_q <= '0;
			end
			// A title bar hit that is not in the close box starts a drag.
			if (state_q == wsee_pkg::S_WIN_CMP && in_win && !in_close && in_title) begin
				drag_q      <= 1'b1;
				drag_slot_q <= slot_q;
				gdx_q       <= 14'(x_p - l_r);
				gdy_q       <= 14'(y_p - t_r);
			end
			if (state_q == wsee_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; slot_out, new_left and new_top read as zero unless the event was done.
	always_ff @(posedge clk) begin
		if (state_q == wsee_pkg::S_DONE && out_free) begin
			res_status_q  <= status_q;
			res_top_q     <= (stk_count != '0) ? 3'(rd_slot) : 3'd0;
			res_count_q   <= 4'(stk_count);
			res_drag_q    <= drag_q;
			res_closed_q  <= closed_q;
			if (status_q == wsee_pkg::STAT_DONE) begin
				res_slot_q    <= 3'(slot_q);
				res_left_q    <= nl_q;
				res_top_pos_q <= nt_q;
			end else begin
				res_slot_q    <= 3'd0;
				res_left_q    <= '0;
				res_top_pos_q <= '0;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = res_status_q;
	assign res.slot_out    = res_slot_q;
	assign res.top_slot    = res_top_q;
	assign res.open_count  = res_count_q;
	assign res.drag_active = res_drag_q;
	assign res.was_closed  = res_closed_q;
	assign res.new_left    = res_left_q;
	assign res.new_top     = res_top_pos_q;

	`WSEE_ASSERT_IMP(a_quiet_fields, clk, arst_n, res.valid && res.status != wsee_pkg::STAT_DONE, res.slot_out == 3'd0 && res.new_left == 13'sd0 && res.new_top == 13'sd0 && !res.was_closed)
	`WSEE_ASSERT_IMP(a_close_is_done, clk, arst_n, res.valid && res.was_closed, res.status == wsee_pkg::STAT_DONE && !res.drag_active || res.status == wsee_pkg::STAT_DONE)
	`WSEE_ASSERT_NXT(a_accept_decodes, clk, arst_n, accept, state_q == wsee_pkg::S_DECODE)
	`WSEE_ASSERT_IMP(a_move_needs_drag, clk, arst_n, state_q == wsee_pkg::S_MOVE_WR, drag_q && visible[drag_slot_q])

endmodule
